// File: design/fstw_pkg.sv
// ----------------------------------------------------------------------------
// fstw_pkg
// shared types and constants of the flagged span trim block
// ----------------------------------------------------------------------------
package fstw_pkg;

  localparam int MAX_ROW_DEF = 1024;
  localparam int AXIS_W      = 2;
  localparam int COUNT_W     = 16;
  localparam int CFG_W       = 11;
  localparam int CFG_ADDR_W  = 1;
  localparam int SPAN_W      = 12;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  localparam logic [CFG_W-1:0] MIN_EDGE_RST = 11'd4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MIN_EDGE        = 1'b0,
    REG_SMALL_ROW_FATAL = 1'b1
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FLAGGED = 2'd1,
    ST_TOO_SMALL  = 2'd2
  } status_t;

  // per-row flags carried from the front part to the back part
  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    logic              seen;
    logic              clr_move;
  } row_ctl_t;

  localparam int ROW_CTL_W = $bits(row_ctl_t);

endpackage

// File: design/fstw_fifo.sv
// ----------------------------------------------------------------------------
// fstw_fifo
// small register queue between the row tracker and the span unit
// ----------------------------------------------------------------------------
module fstw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/fstw_front.sv
// ----------------------------------------------------------------------------
// fstw_front
// row tracker: counts positions and keeps first and last nonzero element
// ----------------------------------------------------------------------------
module fstw_front #(
  parameter int MAX_ROW = fstw_pkg::MAX_ROW_DEF,
  parameter int POS_W   = $clog2(MAX_ROW + 1),
  parameter int IDX_W   = $clog2(MAX_ROW)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [fstw_pkg::AXIS_W-1:0] axis,
  input  logic                       nonzero,
  input  logic                       row_last,
  output logic                       push,
  output fstw_pkg::row_ctl_t         row_ctl,
  output logic [POS_W-1:0]           row_len,
  output logic [IDX_W-1:0]           row_first,
  output logic [IDX_W-1:0]           row_lastnz
);

  import fstw_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             seen_r, seen_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic             clr_r, clr_nxt;

  logic             in_range;
  logic [POS_W-1:0] pos_inc;
  logic             seen_upd;
  logic [IDX_W-1:0] first_upd, last_upd;
  logic             clr_upd;

  always_comb begin
    in_range  = (pos_r < POS_W'(MAX_ROW));
    clr_upd   = (pos_r == '0) ? (axis == '0) : clr_r;
    seen_upd  = seen_r;
    first_upd = first_r;
    last_upd  = last_r;
    pos_inc   = pos_r;
    if (in_range) begin
      pos_inc = pos_r + 1'b1;
      if (nonzero) begin
        if (!seen_r) begin
          first_upd = pos_r[IDX_W-1:0];
        end
        last_upd = pos_r[IDX_W-1:0];
        seen_upd = 1'b1;
      end
    end

    push             = accept && row_last;
    row_ctl.axis     = axis;
    row_ctl.seen     = seen_upd;
    row_ctl.clr_move = clr_upd;
    row_len          = pos_inc;
    row_first        = first_upd;
    row_lastnz       = last_upd;

    pos_nxt   = pos_r;
    seen_nxt  = seen_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    clr_nxt   = clr_r;
    if (accept) begin
      if (row_last) begin
        pos_nxt  = '0;
        seen_nxt = 1'b0;
      end else begin
        pos_nxt   = pos_inc;
        seen_nxt  = seen_upd;
        first_nxt = first_upd;
        last_nxt  = last_upd;
        clr_nxt   = clr_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      seen_r <= 1'b0;
      clr_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      seen_r <= seen_nxt;
      clr_r  <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

endmodule

// File: design/fstw_back.sv
// ----------------------------------------------------------------------------
// fstw_back
// span unit: status, minimum edge widening, move flag and result register
// ----------------------------------------------------------------------------
module fstw_back #(
  parameter int MAX_ROW = fstw_pkg::MAX_ROW_DEF,
  parameter int POS_W   = $clog2(MAX_ROW + 1),
  parameter int IDX_W   = $clog2(MAX_ROW)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         row_valid,
  input  fstw_pkg::row_ctl_t           row_ctl,
  input  logic [POS_W-1:0]             row_len,
  input  logic [IDX_W-1:0]             row_first,
  input  logic [IDX_W-1:0]             row_lastnz,
  output logic                         row_pop,
  input  logic [fstw_pkg::CFG_W-1:0]   min_edge,
  input  logic                         small_row_fatal,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fstw_pkg::status_t            out_status,
  output logic [fstw_pkg::AXIS_W-1:0]  out_axis,
  output logic [fstw_pkg::SPAN_W-1:0]  out_start,
  output logic [fstw_pkg::SPAN_W-1:0]  out_end,
  output logic                         out_move
);

  import fstw_pkg::*;

  localparam int CW = ((POS_W > CFG_W) ? POS_W : CFG_W) + 2;
  localparam logic signed [CW-1:0] ONE_S = CW'(1);

  // stage a
  logic                 a_valid_r;
  status_t              a_status_r, a_status_nxt;
  logic [AXIS_W-1:0]    a_axis_r;
  logic                 a_clr_r;
  logic signed [CW-1:0] a_st_r, a_st_nxt;
  logic signed [CW-1:0] a_en_r, a_en_nxt;
  logic signed [CW-1:0] a_ntot_r, a_ntot_nxt;
  logic signed [CW-1:0] a_mright_r, a_mright_nxt;
  logic                 a_narrow_r, a_narrow_nxt;
  logic                 a_trim_r, a_trim_nxt;
  logic                 a_cover_r, a_cover_nxt;

  logic signed [CW-1:0] me_s, len_s, lenm1_s;
  logic                 adv_a, adv_b;

  // stage b
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [AXIS_W-1:0]    out_axis_r;
  logic [SPAN_W-1:0]    out_start_r;
  logic [SPAN_W-1:0]    out_end_r;
  logic                 move_r, move_nxt;
  logic signed [CW-1:0] n_left, n_right, st_fin, en_fin;
  logic                 move_base;

  assign adv_b   = !out_valid_r || out_ready;
  assign adv_a   = !a_valid_r || adv_b;
  assign row_pop = row_valid && adv_a;

  always_comb begin
    me_s    = signed'(CW'(min_edge));
    len_s   = signed'(CW'(row_len));
    lenm1_s = len_s - ONE_S;

    a_st_nxt     = signed'(CW'(row_first));
    a_en_nxt     = signed'(CW'(row_lastnz));
    a_ntot_nxt   = me_s + a_st_nxt - a_en_nxt - ONE_S;
    a_mright_nxt = lenm1_s - a_en_nxt;
    a_narrow_nxt = (a_en_nxt - a_st_nxt) < me_s;
    a_trim_nxt   = (a_st_nxt != '0) || (a_en_nxt != lenm1_s);
    // widened span always has min_edge cells, so it covers the row iff lengths match
    a_cover_nxt  = (me_s == len_s);

    if (small_row_fatal && (len_s < me_s)) begin
      a_status_nxt = ST_TOO_SMALL;
    end else if (!row_ctl.seen) begin
      a_status_nxt = ST_NO_FLAGGED;
    end else begin
      a_status_nxt = ST_OK;
    end
    if (a_status_nxt != ST_OK) begin
      a_st_nxt     = '0;
      a_en_nxt     = '0;
      a_narrow_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv_a) begin
      a_valid_r <= row_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (row_pop) begin
      a_status_r <= a_status_nxt;
      a_axis_r   <= row_ctl.axis;
      a_clr_r    <= row_ctl.clr_move;
      a_st_r     <= a_st_nxt;
      a_en_r     <= a_en_nxt;
      a_ntot_r   <= a_ntot_nxt;
      a_mright_r <= a_mright_nxt;
      a_narrow_r <= a_narrow_nxt;
      a_trim_r   <= a_trim_nxt;
      a_cover_r  <= a_cover_nxt;
    end
  end

  always_comb begin
    n_left  = a_ntot_r >>> 1;
    n_right = a_ntot_r - n_left;
    st_fin  = a_st_r;
    en_fin  = a_en_r;
    if (a_narrow_r) begin
      if ((n_left <= a_st_r) && (n_right <= a_mright_r)) begin
        st_fin = a_st_r - n_left;
        en_fin = a_en_r + n_right;
      end else if (n_left > a_st_r) begin
        st_fin = '0;
        en_fin = a_en_r + a_ntot_r - a_st_r;
      end else begin
        st_fin = a_st_r - (a_ntot_r - a_mright_r);
        en_fin = a_en_r + a_mright_r;
      end
    end

    move_base = a_clr_r ? 1'b0 : move_r;
    if (a_status_r != ST_OK) begin
      move_nxt = move_base;
    end else if (a_narrow_r && a_cover_r) begin
      move_nxt = 1'b0;
    end else if (a_trim_r) begin
      move_nxt = 1'b1;
    end else begin
      move_nxt = move_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      move_r      <= 1'b0;
    end else if (adv_b) begin
      out_valid_r <= a_valid_r;
      if (a_valid_r) begin
        move_r <= move_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && a_valid_r) begin
      out_status_r <= a_status_r;
      out_axis_r   <= a_axis_r;
      out_start_r  <= st_fin[SPAN_W-1:0];
      out_end_r    <= en_fin[SPAN_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_axis   = out_axis_r;
  assign out_start  = out_start_r;
  assign out_end    = out_end_r;
  assign out_move   = move_r;

endmodule

// File: design/flag_span_trim_with_min_edge_top.sv
// ----------------------------------------------------------------------------
// flag_span_trim_with_min_edge_top
// trims a signature row to its flagged span and widens it to a minimum edge
// ----------------------------------------------------------------------------
// One signature element is accepted every clock unless the queue is full; tlast
// closes a row and that row yields one result beat, registered through the
// queue and then the two stages of the span unit. The row tracker and the span
// unit are decoupled by a two-entry queue, so a stalled result port only backs
// up the input once the queue is full. Each result beat carries status, axis,
// start, end and the running move flag; start and end are 12-bit two's complement local indices.
module flag_span_trim_with_min_edge_top #(
  parameter int MAX_ROW = fstw_pkg::MAX_ROW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fstw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [fstw_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fstw_pkg::IN_DATA_W-1:0]   in_tdata,  // axis, signature_count
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, result_axis, span_start, span_end, move_needed
  output logic [fstw_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import fstw_pkg::*;

  localparam int POS_W = $clog2(MAX_ROW + 1);
  localparam int IDX_W = $clog2(MAX_ROW);
  localparam int Q_W   = ROW_CTL_W + POS_W + 2 * IDX_W;
  localparam int Q_DEPTH = 2;

  logic [CFG_W-1:0]  min_edge_r;
  logic              small_row_fatal_r;

  logic              accept, push, q_full, q_valid, q_pop;
  row_ctl_t          f_ctl, b_ctl;
  logic [POS_W-1:0]  f_len, b_len;
  logic [IDX_W-1:0]  f_first, b_first, f_last, b_last;
  logic [Q_W-1:0]    q_wdata, q_rdata;

  status_t           res_status;
  logic [AXIS_W-1:0] res_axis;
  logic [SPAN_W-1:0] res_start, res_end;
  logic              res_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_edge_r        <= MIN_EDGE_RST;
      small_row_fatal_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_EDGE:        min_edge_r        <= cfg_wdata;
        REG_SMALL_ROW_FATAL: small_row_fatal_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  fstw_front #(
    .MAX_ROW (MAX_ROW),
    .POS_W   (POS_W),
    .IDX_W   (IDX_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .axis       (in_tdata[AXIS_W-1:0]),
    .nonzero    (|in_tdata[AXIS_W+COUNT_W-1:AXIS_W]),
    .row_last   (in_tlast),
    .push       (push),
    .row_ctl    (f_ctl),
    .row_len    (f_len),
    .row_first  (f_first),
    .row_lastnz (f_last)
  );

  assign q_wdata = {f_ctl, f_len, f_first, f_last};
  assign {b_ctl, b_len, b_first, b_last} = q_rdata;

  fstw_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_rdata)
  );

  fstw_back #(
    .MAX_ROW (MAX_ROW),
    .POS_W   (POS_W),
    .IDX_W   (IDX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .row_valid       (q_valid),
    .row_ctl         (b_ctl),
    .row_len         (b_len),
    .row_first       (b_first),
    .row_lastnz      (b_last),
    .row_pop         (q_pop),
    .min_edge        (min_edge_r),
    .small_row_fatal (small_row_fatal_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_status      (res_status),
    .out_axis        (res_axis),
    .out_start       (res_start),
    .out_end         (res_end),
    .out_move        (res_move)
  );

  assign out_tdata = {
    (OUT_DATA_W - STATUS_W - AXIS_W - 2 * SPAN_W - 1)'(0),
    res_move, res_end, res_start, res_axis, res_status
  };

  // no push is ever dropped by a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("row summary pushed into full queue");

  // a rejected row reports an empty span
  a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_status != ST_OK)) |-> ((res_start == '0) && (res_end == '0)))
    else $error("nonzero span on a rejected row");

  // too small is only reported when the fatal check is enabled
  a_fatal_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res_status == ST_TOO_SMALL)) |-> small_row_fatal_r)
    else $error("too small status with fatal check off");

  // a result beat only appears after a queue entry was drained
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_tvalid)) |-> $past(q_pop, 2))
    else $error("result beat without a drained row");

endmodule

// File: bench/flag_span_trim_with_min_edge_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flag_span_trim_with_min_edge_top_tb
// self-checking bench for the flagged span trim with minimum edge
// ----------------------------------------------------------------------------
// Signature rows are queued by the stimulus process and offered one beat per
// clock, unless a beat is held until taken, by a driver with random gaps. Every
// accepted beat is run through a local model of the row tracker; a row end pushes
// the predicted span. The monitor pops the oldest prediction on every result beat
// and compares all fields. Phases change min_edge and the fatal check while the
// block is idle, vary the idling on both sides and hold the result port off for a long run.
module flag_span_trim_with_min_edge_top_tb;
  import fstw_pkg::*;

  localparam int MAX_ROW      = fstw_pkg::MAX_ROW_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    logic [AXIS_W-1:0]  axis;
    logic [COUNT_W-1:0] count;
    logic               row_last;
  } sig_beat_t;

  typedef struct {
    status_t             status;
    logic [AXIS_W-1:0]   axis;
    logic [SPAN_W-1:0]   start_idx;
    logic [SPAN_W-1:0]   end_idx;
    logic                move;
  } span_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // axis, signature_count
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // status, result_axis, span_start, span_end, move_needed
  logic [OUT_DATA_W-1:0] out_tdata;

  sig_beat_t pending_q[$];
  span_res_t span_q[$];
  sig_beat_t cur_beat;

  // row tracker model state and register copies
  int   row_pos = 0;
  bit   seen_flag = 1'b0;
  int   first_pos = 0;
  int   last_pos = 0;
  bit   move_flag = 1'b0;
  int   min_edge_cfg = int'(MIN_EDGE_RST);
  bit   fatal_cfg = 1'b0;

  int   items_queued = 0;
  int   items_taken = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   phase_cnt = 0;
  int   next_axis = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_left = 0;
  int   cycle_cnt = 0;

  flag_span_trim_with_min_edge_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic track_beat(input sig_beat_t b);
    int len, st, en, me, m_l, m_r, n_t, n_l, n_r;
    span_res_t r;
    if (row_pos == 0 && b.axis == '0) move_flag = 1'b0;
    if (row_pos < MAX_ROW) begin
      if (b.count != '0) begin
        if (!seen_flag) first_pos = row_pos;
        last_pos = row_pos;
        seen_flag = 1'b1;
      end
      row_pos++;
    end
    if (!b.row_last) return;
    len = row_pos;
    st = 0;
    en = 0;
    me = min_edge_cfg;
    r.status = ST_OK;
    if (fatal_cfg && len < me) begin
      r.status = ST_TOO_SMALL;
    end else if (!seen_flag) begin
      r.status = ST_NO_FLAGGED;
    end else begin
      st = first_pos;
      en = last_pos;
      if (st != 0 || en != len - 1) move_flag = 1'b1;
      if (en - st < me) begin
        m_l = st;
        m_r = len - 1 - en;
        n_t = me + st - en - 1;
        n_l = n_t / 2;
        n_r = n_t - n_l;
        if (n_l <= m_l && n_r <= m_r) begin
          st -= n_l;
          en += n_r;
        end else if (n_l > m_l) begin
          st -= m_l;
          en += n_t - m_l;
        end else begin
          st -= n_t - m_r;
          en += m_r;
        end
        if (en - st == len - 1) move_flag = 1'b0;
      end
    end
    r.axis = b.axis;
    r.start_idx = st[SPAN_W-1:0];
    r.end_idx = en[SPAN_W-1:0];
    r.move = move_flag;
    span_q.push_back(r);
    row_pos = 0;
    seen_flag = 1'b0;
    first_pos = 0;
    last_pos = 0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_beat(cur_beat);
        items_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat = pending_q.pop_front();
          in_tdata <= {{(IN_DATA_W-COUNT_W-AXIS_W){1'b0}}, cur_beat.count, cur_beat.axis};
          in_tlast <= cur_beat.row_last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_span(input logic [OUT_DATA_W-1:0] d);
    span_res_t e;
    results_seen++;
    if (span_q.size() == 0) begin
      $display("%0t: result beat expected none got 0x%08h", $time, d);
      errors++;
      return;
    end
    e = span_q.pop_front();
    check_field("status", int'(e.status), int'(d[1:0]));
    check_field("result_axis", int'(e.axis), int'(d[3:2]));
    check_field("span_start", int'(e.start_idx), int'(d[15:4]));
    check_field("span_end", int'(e.end_idx), int'(d[27:16]));
    check_field("move_needed", int'(e.move), int'(d[28]));
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_span(out_tdata);
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_beat(input int axis, input int count, input bit last);
    sig_beat_t b;
    b.axis = axis[AXIS_W-1:0];
    b.count = count[COUNT_W-1:0];
    b.row_last = last;
    pending_q.push_back(b);
    items_queued++;
  endtask

  task automatic queue_fixed_row(input int axis, input int vals[$]);
    foreach (vals[i]) queue_beat(axis, vals[i], i == vals.size() - 1);
  endtask

  task automatic queue_row(input int axis, input int len, input int mode, input bit mixed);
    bit hit;
    int a;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0:       hit = 1'b0;
        1:       hit = $urandom_range(99) < 15;
        2:       hit = $urandom_range(99) < 60;
        default: hit = 1'b1;
      endcase
      a = mixed ? $urandom_range(3) : axis;
      queue_beat(a, hit ? $urandom_range(16'hFFFF, 1) : 0, i == len - 1);
    end
  endtask

  task automatic queue_random_rows(input int n_items);
    int stop_at, pick, len, ax;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) len = $urandom_range(6, 1);
      else if (pick < 97) len = $urandom_range(30, 7);
      else len = $urandom_range(100, 31);
      ax = ($urandom_range(99) < 5) ? 3 : next_axis;
      queue_row(ax, len, $urandom_range(3), $urandom_range(99) < 6);
      next_axis = (next_axis == 2) ? 0 : next_axis + 1;
    end
  endtask

  task automatic set_config(input int me, input bit fatal);
    cfg_we <= 1'b1;
    cfg_addr <= REG_MIN_EDGE;
    cfg_wdata <= me[CFG_W-1:0];
    @(posedge clk);
    min_edge_cfg = me & ((1 << CFG_W) - 1);
    cfg_addr <= REG_SMALL_ROW_FATAL;
    cfg_wdata <= {{(CFG_W-1){1'b0}}, fatal};
    @(posedge clk);
    fatal_cfg = fatal;
    cfg_we <= 1'b0;
  endtask

  task automatic start_phase(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    phase_cnt++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (items_taken != items_queued || span_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("flag_span_trim_with_min_edge_top: mismatch");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: single cell, empty row, centered widening, axis 3,
    // mixed axes, already wide enough
    start_phase(0, 0);
    queue_fixed_row(0, '{16'hFFFF});
    queue_fixed_row(1, '{0, 0, 0});
    queue_fixed_row(2, '{0, 0, 1, 0, 0});
    queue_fixed_row(3, '{16'h8000});
    queue_beat(0, 1, 1'b0);
    queue_beat(1, 0, 1'b0);
    queue_beat(2, 0, 1'b1);
    queue_fixed_row(1, '{16'h5555, 16'hAAAA, 2, 16'hFFFF});
    wait_idle();

    // too small rows, then a widening that covers the whole row
    set_config(8, 1'b1);
    start_phase(0, 0);
    queue_fixed_row(0, '{0, 7, 0});
    queue_fixed_row(1, '{0});
    queue_fixed_row(2, '{0, 0, 0, 1, 0, 0, 0, 0});
    wait_idle();

    set_config(1, 1'b0);
    start_phase(0, 0);
    queue_random_rows(80);
    wait_idle();

    set_config($urandom_range(12, 2), 1'b1);
    start_phase(66, 0);
    queue_random_rows(100);
    wait_idle();

    // edge as wide as the row limit, spans leave the row
    set_config(1024, 1'b0);
    start_phase(0, 66);
    queue_random_rows(100);
    wait_idle();

    // overlong row beyond the row limit
    set_config($urandom_range(20, 3), 1'b1);
    start_phase(17, 17);
    queue_row(0, $urandom_range(1040, 1025), 1, 1'b0);
    queue_random_rows(60);
    wait_idle();

    // result port held off while rows keep coming
    set_config(5, 1'b1);
    start_phase(0, 0);
    hold_left <= HOLD_CYCLES;
    queue_random_rows(100);
    wait_idle();

    repeat (20) @(posedge clk);
    $display("run covered %0d signature beats and %0d span results", items_taken,
             results_seen);
    $display("over %0d register settings and idling phases, %0d errors", phase_cnt, errors);
    if (errors == 0) begin
      $display("flag_span_trim_with_min_edge_top: match");
    end else begin
      $display("flag_span_trim_with_min_edge_top: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
design/fstw_pkg.sv
design/fstw_fifo.sv
design/fstw_front.sv
design/fstw_back.sv
design/flag_span_trim_with_min_edge_top.sv
bench/flag_span_trim_with_min_edge_top_tb.sv
